/* hdl/bcpf_pkg.sv */
// ----------------------------------------------------------------------------
// bcpf_pkg
// Shared types and constants of the board command packet framer: link word
// codes, command kinds, status codes and the frame descriptor.
// ----------------------------------------------------------------------------
package bcpf_pkg;

  localparam int SLOT_N = 10;

  // word slots of a descriptor, emitted from the lowest index up
  localparam int SLOT_PRE   = 0;
  localparam int SLOT_SEL   = 1;
  localparam int SLOT_DST   = 2;
  localparam int SLOT_OPEN  = 3;
  localparam int SLOT_HDR   = 4;
  localparam int SLOT_EL0   = 5;
  localparam int SLOT_EL1   = 6;
  localparam int SLOT_TRAIL = 7;
  localparam int SLOT_REQ   = 8;
  localparam int SLOT_ERR   = 9;

  typedef logic [SLOT_N-1:0] slot_mask_t;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_MEM   = 2'd2;
  localparam logic [1:0] KIND_ORDER = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_COUNT = 2'd1;
  localparam logic [1:0] STATUS_BAD_DEST  = 2'd2;

  localparam logic [31:0] WORD_SYNC    = 32'h8fff0000;
  localparam logic [31:0] WORD_SELECT  = 32'h90000000;
  localparam logic [31:0] WORD_OPEN    = 32'hc0000000;
  localparam logic [31:0] WORD_REQUEST = 32'ha0000000;
  localparam logic [31:0] HDR_READ     = 32'h20000000;
  localparam logic [31:0] HDR_WRITE    = 32'h80000000;
  localparam logic [31:0] HDR_MEM      = 32'hc0000000;

  localparam logic [11:0] DEST_INVALID    = 12'hfff;
  localparam logic [11:0] ORDER_DEST_BASE = 12'h0ff;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    slot_mask_t  slots;
    logic [11:0] dest;
    logic [31:0] header;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [1:0]  status;
  } desc_t;

endpackage

/* hdl/bcpf_front.sv */
// ----------------------------------------------------------------------------
// bcpf_front
// Accepts command items, checks and tracks the active command and turns each
// item into a descriptor of the link words it causes.
// ----------------------------------------------------------------------------
module bcpf_front #(
  parameter int MAX_PAYLOAD_WORDS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [1:0]      req_type,
  input  logic            first_item,
  input  logic [11:0]     dest,
  input  logic [9:0]      count,
  input  logic [13:0]     reg_addr,
  input  logic [31:0]     data_value,
  input  logic            wait_flag,
  input  logic [13:0]     wait_addr,
  input  logic [5:0]      mem_sel,
  input  logic [13:0]     start_addr,
  input  logic            board_mask_wr_en,
  input  logic [11:0]     board_mask_wr_data,
  input  logic            q_full,
  output logic            push,
  output bcpf_pkg::desc_t push_desc
);
  import bcpf_pkg::*;

  localparam logic [10:0] MAX_W = 11'(MAX_PAYLOAD_WORDS);

  logic [11:0] board_mask;
  logic [9:0]  elements_left;
  logic [1:0]  active_kind;
  logic [11:0] active_dest;

  logic        accept;
  logic        bad_count;
  logic        bad_dest;
  logic        start_ok;
  logic        do_elem;
  logic [1:0]  kind_use;
  logic [9:0]  cnt_use;
  logic [9:0]  left_after;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign kind_use   = first_item ? req_type : active_kind;
  assign cnt_use    = first_item ? count : elements_left;
  assign left_after = cnt_use - 10'd1;

  always_comb begin
    if (req_type == KIND_WRITE) begin
      bad_count = (count == 10'd0) || ({count, 1'b0} > MAX_W);
    end else begin
      bad_count = (count == 10'd0) || ({1'b0, count} > MAX_W);
    end
  end

  assign bad_dest = (req_type == KIND_READ) && (dest == DEST_INVALID);
  assign start_ok = first_item && (req_type != KIND_ORDER) && !bad_count && !bad_dest;
  assign do_elem  = start_ok || (!first_item && (elements_left != 10'd0));

  always_comb begin
    push_desc        = '0;
    push_desc.word1  = data_value;
    push_desc.dest   = first_item ? dest : active_dest;
    case (kind_use)
      KIND_READ:  push_desc.word0 = {18'd0, reg_addr};
      KIND_WRITE: push_desc.word0 = {3'd0, wait_flag, wait_addr, reg_addr};
      default:    push_desc.word0 = data_value;
    endcase
    case (req_type)
      KIND_READ:  push_desc.header = HDR_READ | {8'd0, count, 14'd0};
      KIND_WRITE: push_desc.header = HDR_WRITE | {8'd0, count, 14'd0};
      default:    push_desc.header = HDR_MEM | {2'd0, mem_sel, count, start_addr};
    endcase
    if (first_item && (req_type == KIND_ORDER)) begin
      push_desc.slots[SLOT_PRE]   = 1'b1;
      push_desc.slots[SLOT_SEL]   = 1'b1;
      push_desc.slots[SLOT_DST]   = 1'b1;
      push_desc.slots[SLOT_OPEN]  = 1'b1;
      push_desc.slots[SLOT_HDR]   = 1'b1;
      push_desc.slots[SLOT_TRAIL] = 1'b1;
      push_desc.header            = '0;
      push_desc.dest              = ORDER_DEST_BASE | board_mask;
    end else if (first_item && !start_ok) begin
      push_desc.slots[SLOT_ERR] = 1'b1;
      push_desc.status          = bad_count ? STATUS_BAD_COUNT : STATUS_BAD_DEST;
    end else if (do_elem) begin
      push_desc.slots[SLOT_SEL]   = first_item;
      push_desc.slots[SLOT_DST]   = first_item;
      push_desc.slots[SLOT_OPEN]  = first_item;
      push_desc.slots[SLOT_HDR]   = first_item;
      push_desc.slots[SLOT_EL0]   = 1'b1;
      push_desc.slots[SLOT_EL1]   = (kind_use == KIND_WRITE);
      push_desc.slots[SLOT_TRAIL] = (left_after == 10'd0);
      push_desc.slots[SLOT_REQ]   = (left_after == 10'd0) && (kind_use == KIND_READ);
    end
  end

  assign push = accept && (push_desc.slots != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      board_mask    <= '0;
      elements_left <= '0;
      active_kind   <= KIND_READ;
      active_dest   <= '0;
    end else begin
      if (board_mask_wr_en) begin
        board_mask <= board_mask_wr_data;
      end
      if (accept) begin
        if (first_item) begin
          elements_left <= start_ok ? left_after : 10'd0;
          if (start_ok) begin
            active_kind <= req_type;
            active_dest <= dest;
          end
        end else if (elements_left != 10'd0) begin
          elements_left <= left_after;
        end
      end
    end
  end

endmodule

/* hdl/bcpf_queue.sv */
// ----------------------------------------------------------------------------
// bcpf_queue
// Short descriptor queue between the front and back parts of the framer.
// ----------------------------------------------------------------------------
module bcpf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bcpf_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output bcpf_pkg::desc_t head
);
  import bcpf_pkg::*;

  desc_t               entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign full  = (fill == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |-> !push)
    else $error("push into full queue");

endmodule

/* hdl/bcpf_back.sv */
// ----------------------------------------------------------------------------
// bcpf_back
// Walks the word slots of the head descriptor and sends one link word per
// cycle, while the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module bcpf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  bcpf_pkg::desc_t q_head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [31:0]     m_tdata,
  output logic            m_tlast,
  output logic [2:0]      m_tuser
);
  import bcpf_pkg::*;

  slot_mask_t  done;
  slot_mask_t  remaining;
  slot_mask_t  sel;
  slot_mask_t  rest;
  logic        load;
  logic [31:0] word;
  logic        eof;
  logic [1:0]  status;

  assign remaining = q_head.slots & ~done;
  assign sel       = remaining & (~remaining + 1'b1);
  assign rest      = remaining & ~sel;
  assign load      = !q_empty && (!m_tvalid || m_tready);
  assign pop       = load && (rest == '0);

  always_comb begin
    word   = '0;
    eof    = 1'b0;
    status = STATUS_OK;
    if (sel[SLOT_PRE] || sel[SLOT_SEL]) begin
      word = WORD_SYNC;
      eof  = 1'b1;
    end else if (sel[SLOT_DST]) begin
      word = WORD_SELECT | {4'd0, q_head.dest, 16'd0};
      eof  = 1'b1;
    end else if (sel[SLOT_OPEN]) begin
      word = WORD_OPEN;
    end else if (sel[SLOT_HDR]) begin
      word = q_head.header;
    end else if (sel[SLOT_EL0]) begin
      word = q_head.word0;
    end else if (sel[SLOT_EL1]) begin
      word = q_head.word1;
    end else if (sel[SLOT_TRAIL]) begin
      eof = 1'b1;
    end else if (sel[SLOT_REQ]) begin
      word = WORD_REQUEST | {4'd0, q_head.dest, 16'd0};
      eof  = 1'b1;
    end else if (sel[SLOT_ERR]) begin
      status = q_head.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      done     <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        done     <= (rest == '0) ? '0 : (done | sel);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= word;
      m_tlast <= eof;
      m_tuser <= {status, rest == '0};
    end
  end

  a_head_has_work: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (remaining != '0))
    else $error("queued descriptor with no words left");

  a_done_clear_idle: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> (done == '0))
    else $error("slot progress left over with empty queue");

  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[2:1] != STATUS_OK)) |-> (m_tuser[0] && !m_tlast && m_tdata == '0))
    else $error("malformed error item");

endmodule

/* hdl/board_command_packet_framer_core.sv */
// ----------------------------------------------------------------------------
// board_command_packet_framer_core
// Command frame builder for a front-end board link.
// ----------------------------------------------------------------------------
// Each input item is one command element; it yields zero to seven link words
// on the output, one word per clock when the output is ready. An item causes
// one word for a read or memory element, two for a write element, one more on
// the last element of a command for the trailer and one more again for the
// request frame of a read, up to seven for the first item of a command
// (select, destination, data header, element, trailer and request frames). The
// output word stage sets the word rate; the front part takes a new item every
// cycle as long as its four-entry descriptor queue has room, so item intake
// and word output stall independently of each other.
// ----------------------------------------------------------------------------
module board_command_packet_framer_core #(
  parameter int MAX_PAYLOAD_WORDS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // dest, count, reg_addr, data_value, wait_flag, wait_addr, mem_sel,
  // start_addr, zero pad
  input  logic [103:0] s_tdata,
  // req_type, first_item
  input  logic [2:0]   s_tuser,
  input  logic         board_mask_wr_en,
  input  logic [11:0]  board_mask_wr_data,
  output logic         m_tvalid,
  input  logic         m_tready,
  // link_word
  output logic [31:0]  m_tdata,
  // end_of_frame
  output logic         m_tlast,
  // last_result, status
  output logic [2:0]   m_tuser
);
  import bcpf_pkg::*;

  desc_t push_desc;
  desc_t q_head;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;

  bcpf_front #(
    .MAX_PAYLOAD_WORDS(MAX_PAYLOAD_WORDS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .req_type          (s_tuser[1:0]),
    .first_item        (s_tuser[2]),
    .dest              (s_tdata[11:0]),
    .count             (s_tdata[21:12]),
    .reg_addr          (s_tdata[35:22]),
    .data_value        (s_tdata[67:36]),
    .wait_flag         (s_tdata[68]),
    .wait_addr         (s_tdata[82:69]),
    .mem_sel           (s_tdata[88:83]),
    .start_addr        (s_tdata[102:89]),
    .board_mask_wr_en  (board_mask_wr_en),
    .board_mask_wr_data(board_mask_wr_data),
    .q_full            (q_full),
    .push              (push),
    .push_desc         (push_desc)
  );

  bcpf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  bcpf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule
